// File: src/ttva_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tagged time value ALU package
// Shared widths, arithmetic constants, operation codes and the result word
// that travels between the time-value datapath and the top level.
// ----------------------------------------------------------------------------
package ttva_pkg;

  localparam int SEC_BITS_DEF = 48;
  localparam int NSEC_W       = 31;
  localparam int SER_W        = 58;
  localparam int ORD_W        = 2;
  localparam int OP_W         = 3;

  localparam int ST_N         = 8;
  localparam int TIME_ST      = 4;

  localparam longint NS_PER_SEC = 64'sd1000000000;
  localparam longint NS_PER_MS  = 64'sd1000000;
  localparam longint MS_PER_SEC = 64'sd1000;

  // nanoseconds to milliseconds: exact reciprocal for magnitudes below 2^31
  localparam longint K_NS_MS     = 64'sd2251799814;
  localparam int     NS_MS_SHIFT = 51;
  localparam int     NS_MSQ_W    = 11;
  localparam int     AN_P_W      = 63;

  // milliseconds to seconds: long division, one 20-bit chunk per step
  localparam longint K_MS      = 64'sd1099511628;
  localparam int     MS_SHIFT  = 40;
  localparam int     CHUNK_W   = 20;
  localparam int     REM_W     = 10;
  localparam int     DIV_X_W   = CHUNK_W + REM_W;
  localparam int     DIV_P_W   = 61;
  localparam int     MAG_W     = 3 * CHUNK_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD         = 3'd0,
    OP_SUB         = 3'd1,
    OP_CMP         = 3'd2,
    OP_TO_MS       = 3'd3,
    OP_FROM_MS_REL = 3'd4,
    OP_FROM_MS_ABS = 3'd5
  } op_t;

  localparam logic [ORD_W-1:0] ORD_LT = 2'b11;
  localparam logic [ORD_W-1:0] ORD_EQ = 2'b00;
  localparam logic [ORD_W-1:0] ORD_GT = 2'b01;

  typedef struct packed {
    logic [NSEC_W-1:0] r_nsec;
    logic [ORD_W-1:0]  order;
    logic [SER_W-1:0]  serial_out;
    logic              error;
  } tv_res_t;

endpackage
`default_nettype wire

// File: src/ttva_div_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Divide-by-1000 step
// One long-division step: a 30-bit partial dividend is multiplied by the
// reciprocal of 1000 in the first stage, quotient chunk and remainder are
// formed in the second.
// ----------------------------------------------------------------------------
module ttva_div_step (
  input  wire logic                           clk,
  input  wire logic                           en_mul,
  input  wire logic                           en_rem,
  input  wire logic [ttva_pkg::DIV_X_W-1:0]   x,
  output logic      [ttva_pkg::CHUNK_W-1:0]   q,
  output logic      [ttva_pkg::REM_W-1:0]     rem
);
  import ttva_pkg::*;

  logic [DIV_X_W-1:0] xm;
  logic [DIV_P_W-1:0] pm;
  logic [CHUNK_W-1:0] q_next;
  logic [DIV_X_W-1:0] r_full;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      xm <= x;
      pm <= DIV_P_W'(x) * DIV_P_W'(K_MS);
    end
  end

  always_comb begin
    q_next = pm[MS_SHIFT+CHUNK_W-1:MS_SHIFT];
    r_full = xm - DIV_X_W'(q_next) * DIV_X_W'(MS_PER_SEC);
  end

  always_ff @(posedge clk) begin
    if (en_rem) begin
      q   <= q_next;
      rem <= r_full[REM_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: src/ttva_time.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Time value datapath
// Add, subtract, compare and to-milliseconds over four register stages:
// raw sums, coarse renormalisation, sign fix-up, result select.
// ----------------------------------------------------------------------------
module ttva_time #(
  parameter int SEC_BITS = ttva_pkg::SEC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic [ttva_pkg::TIME_ST-1:0]       adv,
  input  wire logic [ttva_pkg::OP_W-1:0]          op,
  input  wire logic signed [SEC_BITS-1:0]         a_sec,
  input  wire logic signed [ttva_pkg::NSEC_W-1:0] a_nsec,
  input  wire logic signed [SEC_BITS-1:0]         b_sec,
  input  wire logic signed [ttva_pkg::NSEC_W-1:0] b_nsec,
  output logic      [SEC_BITS-1:0]                r_sec,
  output ttva_pkg::tv_res_t                       res
);
  import ttva_pkg::*;

  localparam int SW  = SEC_BITS;
  localparam int SOW = (SEC_BITS + 11 > SER_W + 1) ? SEC_BITS + 11 : SER_W + 1;
  localparam logic signed [NSEC_W:0]   E9W   = (NSEC_W+1)'(NS_PER_SEC);
  localparam logic signed [NSEC_W:0]   E9X2  = (NSEC_W+1)'(2 * NS_PER_SEC);
  localparam logic signed [NSEC_W-1:0] E9    = NSEC_W'(NS_PER_SEC);
  localparam logic signed [SW+1:0]     ONE_S = (SW+2)'(1);

  // stage 0
  logic               a_rel, b_rel;
  logic signed [NSEC_W:0] an_x, bn_e, sum_n, dif_n, rn_n;
  logic signed [SW:0]     as_x, bs_x, rs_n;
  logic               errk_n;
  logic signed [SOW-1:0]  asw;

  logic [OP_W-1:0]        op_s0;
  logic signed [NSEC_W:0] rn_s0;
  logic signed [SW:0]     rs_s0;
  logic                   errk_s0, slt_s0, seq_s0, nlt_s0, neq_s0, aneg_s0;
  logic [NSEC_W-1:0]      amag_s0;
  logic signed [SOW-1:0]  p1_s0;
  logic signed [SW-1:0]   asec_s0;

  always_comb begin
    a_rel  = a_nsec[0];
    b_rel  = b_nsec[0];
    an_x   = {a_nsec[NSEC_W-1], a_nsec};
    bn_e   = {b_nsec[NSEC_W-1], b_nsec[NSEC_W-1:1], 1'b0};
    sum_n  = an_x + bn_e;
    dif_n  = an_x - bn_e;
    as_x   = {a_sec[SW-1], a_sec};
    bs_x   = {b_sec[SW-1], b_sec};
    asw    = {{(SOW-SW){a_sec[SW-1]}}, a_sec};
    rn_n   = sum_n;
    rs_n   = as_x + bs_x;
    errk_n = 1'b0;
    case (op_t'(op))
      OP_ADD: begin
        rn_n   = b_rel ? sum_n : {sum_n[NSEC_W:1], 1'b0};
        errk_n = !a_rel && !b_rel;
      end
      OP_SUB: begin
        rn_n   = b_rel ? dif_n : {dif_n[NSEC_W:1], 1'b1};
        rs_n   = as_x - bs_x;
        errk_n = a_rel && !b_rel;
      end
      OP_CMP: errk_n = a_rel ^ b_rel;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      op_s0   <= op;
      rn_s0   <= rn_n;
      rs_s0   <= rs_n;
      errk_s0 <= errk_n;
      slt_s0  <= a_sec < b_sec;
      seq_s0  <= a_sec == b_sec;
      nlt_s0  <= a_nsec < b_nsec;
      neq_s0  <= a_nsec == b_nsec;
      aneg_s0 <= a_nsec[NSEC_W-1];
      amag_s0 <= a_nsec[NSEC_W-1] ? NSEC_W'(-a_nsec) : NSEC_W'(a_nsec);
      p1_s0   <= (asw <<< 10) - (asw <<< 4);
      asec_s0 <= a_sec;
    end
  end

  // stage 1
  logic signed [NSEC_W:0]   rn1_n;
  logic signed [2:0]        qadj;
  logic signed [SOW-1:0]    asw1;

  logic [OP_W-1:0]          op_s1;
  logic signed [SW+1:0]     rs_s1;
  logic signed [NSEC_W-1:0] rn_s1;
  logic                     errk_s1, slt_s1, seq_s1, nlt_s1, neq_s1, aneg_s1;
  logic [AN_P_W-1:0]        prod_s1;
  logic signed [SOW-1:0]    a1000_s1;

  always_comb begin
    asw1 = {{(SOW-SW){asec_s0[SW-1]}}, asec_s0};
    if (rn_s0 >= E9X2) begin
      rn1_n = rn_s0 - E9X2;
      qadj  = 3'sd2;
    end else if (rn_s0 >= E9W) begin
      rn1_n = rn_s0 - E9W;
      qadj  = 3'sd1;
    end else if (rn_s0 <= -E9X2) begin
      rn1_n = rn_s0 + E9X2;
      qadj  = -3'sd2;
    end else if (rn_s0 <= -E9W) begin
      rn1_n = rn_s0 + E9W;
      qadj  = -3'sd1;
    end else begin
      rn1_n = rn_s0;
      qadj  = 3'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      op_s1    <= op_s0;
      rs_s1    <= {rs_s0[SW], rs_s0} + {{(SW-1){qadj[2]}}, qadj};
      rn_s1    <= rn1_n[NSEC_W-1:0];
      errk_s1  <= errk_s0;
      slt_s1   <= slt_s0;
      seq_s1   <= seq_s0;
      nlt_s1   <= nlt_s0;
      neq_s1   <= neq_s0;
      aneg_s1  <= aneg_s0;
      prod_s1  <= AN_P_W'(amag_s0) * AN_P_W'(K_NS_MS);
      a1000_s1 <= p1_s0 - (asw1 <<< 3);
    end
  end

  // stage 2
  logic                     rs_pos, rn_pos;
  logic signed [SW+1:0]     rs2_n;
  logic signed [NSEC_W-1:0] rn2_n;
  logic [NS_MSQ_W-1:0]      anq;
  logic [ORD_W-1:0]         ord_n;

  logic [OP_W-1:0]          op_s2;
  logic signed [SW+1:0]     rs_s2;
  logic signed [NSEC_W-1:0] rn_s2;
  logic                     errk_s2, errt_s2;
  logic signed [NS_MSQ_W:0] anqs_s2;
  logic signed [SOW-1:0]    a1000_s2;
  logic [ORD_W-1:0]         ord_s2;

  always_comb begin
    rs_pos = !rs_s1[SW+1] && (rs_s1 != '0);
    rn_pos = !rn_s1[NSEC_W-1] && (rn_s1 != '0);
    rs2_n  = rs_s1;
    rn2_n  = rn_s1;
    if (rs_pos && rn_s1[NSEC_W-1]) begin
      rn2_n = rn_s1 + E9;
      rs2_n = rs_s1 - ONE_S;
    end else if (rs_s1[SW+1] && rn_pos) begin
      rn2_n = rn_s1 - E9;
      rs2_n = rs_s1 + ONE_S;
    end
    anq   = prod_s1[NS_MS_SHIFT+NS_MSQ_W-1:NS_MS_SHIFT];
    ord_n = ORD_EQ;
    if (!seq_s1) begin
      ord_n = slt_s1 ? ORD_LT : ORD_GT;
    end else if (!neq_s1) begin
      ord_n = nlt_s1 ? ORD_LT : ORD_GT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      op_s2    <= op_s1;
      rs_s2    <= rs2_n;
      rn_s2    <= rn2_n;
      errk_s2  <= errk_s1;
      errt_s2  <= (!rn2_n[0] && (rs2_n[SW+1] || rn2_n[NSEC_W-1])) ||
                  !((&rs2_n[SW+1:SW-1]) || !(|rs2_n[SW+1:SW-1]));
      anqs_s2  <= aneg_s1 ? -$signed({1'b0, anq}) : $signed({1'b0, anq});
      a1000_s2 <= a1000_s1;
      ord_s2   <= ord_n;
    end
  end

  // stage 3
  logic signed [SOW-1:0] so_full;
  logic                  err_so;
  logic [SW-1:0]         rsec_n;
  tv_res_t               res_n;

  always_comb begin
    so_full = a1000_s2 + {{(SOW-NS_MSQ_W-1){anqs_s2[NS_MSQ_W]}}, anqs_s2};
    err_so  = !((&so_full[SOW-1:SER_W-1]) || !(|so_full[SOW-1:SER_W-1]));
    rsec_n  = '0;
    res_n   = '0;
    case (op_t'(op_s2))
      OP_ADD, OP_SUB: begin
        rsec_n       = rs_s2[SW-1:0];
        res_n.r_nsec = rn_s2;
        res_n.error  = errk_s2 || errt_s2;
      end
      OP_CMP: begin
        res_n.order = ord_s2;
        res_n.error = errk_s2;
      end
      OP_TO_MS: begin
        res_n.serial_out = so_full[SER_W-1:0];
        res_n.error      = err_so;
      end
      OP_FROM_MS_REL, OP_FROM_MS_ABS: ;
      default: res_n.error = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      r_sec <= rsec_n;
      res   <= res_n;
    end
  end

endmodule
`default_nettype wire

// File: src/tagged_time_value_alu_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tagged time value ALU
// Seconds-plus-nanoseconds arithmetic with a relative/absolute tag in the
// nanosecond LSB.
// ----------------------------------------------------------------------------
// Every request word gives exactly one response word, in order. The datapath
// is an eight-stage pipeline, so one word is taken per cycle while the
// response side keeps up; each stage holds its word only while the stage
// after it is full and stalled, so empty stages keep accepting while a
// finished response waits. The from-milliseconds split is a three-step long
// division by 1000 (a 30 x 31 bit reciprocal multiply per step) and sets the
// pipeline depth.
module tagged_time_value_alu_core #(
  parameter int SEC_BITS = ttva_pkg::SEC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               req_valid,
  output logic                                    req_ready,
  input  wire logic [ttva_pkg::OP_W-1:0]          op,
  input  wire logic signed [SEC_BITS-1:0]         a_sec,
  input  wire logic signed [ttva_pkg::NSEC_W-1:0] a_nsec,
  input  wire logic signed [SEC_BITS-1:0]         b_sec,
  input  wire logic signed [ttva_pkg::NSEC_W-1:0] b_nsec,
  input  wire logic signed [ttva_pkg::SER_W-1:0]  serial_in,
  output logic                                    rsp_valid,
  input  wire logic                               rsp_ready,
  output logic signed [SEC_BITS-1:0]              r_sec,
  output logic signed [ttva_pkg::NSEC_W-1:0]      r_nsec,
  output logic signed [ttva_pkg::ORD_W-1:0]       order,
  output logic signed [ttva_pkg::SER_W-1:0]       serial_out,
  output logic                                    error
);
  import ttva_pkg::*;

  localparam int SW = SEC_BITS;

  logic [ST_N-1:0] vld;
  logic [ST_N:0]   adv;
  logic [OP_W-1:0] opq [ST_N];
  logic            sneg [ST_N-1];

  always_comb begin
    adv[ST_N] = rsp_ready;
    for (int k = ST_N - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign req_ready = adv[0];
  assign rsp_valid = vld[ST_N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= req_valid;
      end
      for (int k = 1; k < ST_N; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  logic signed [MAG_W-1:0] ser_x;
  logic [MAG_W-1:0]        smag;

  assign ser_x = {{(MAG_W-SER_W){serial_in[SER_W-1]}}, serial_in};

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      opq[0]  <= op;
      sneg[0] <= serial_in[SER_W-1];
      smag    <= serial_in[SER_W-1] ? MAG_W'(-ser_x) : MAG_W'(ser_x);
    end
    for (int k = 1; k < ST_N; k++) begin
      if (adv[k]) begin
        opq[k] <= opq[k-1];
      end
    end
    for (int k = 1; k < ST_N - 1; k++) begin
      if (adv[k]) begin
        sneg[k] <= sneg[k-1];
      end
    end
  end

  // time value datapath, stages 0 to 3
  logic [SW-1:0] rsec_t;
  tv_res_t       res_t;

  ttva_time #(
    .SEC_BITS (SEC_BITS)
  ) u_time (
    .clk    (clk),
    .adv    (adv[TIME_ST-1:0]),
    .op     (op),
    .a_sec  (a_sec),
    .a_nsec (a_nsec),
    .b_sec  (b_sec),
    .b_nsec (b_nsec),
    .r_sec  (rsec_t),
    .res    (res_t)
  );

  logic [SW-1:0] rsec_s4, rsec_s5, rsec_s6;
  tv_res_t       res_s4, res_s5, res_s6;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      rsec_s4 <= rsec_t;
      res_s4  <= res_t;
    end
    if (adv[5]) begin
      rsec_s5 <= rsec_s4;
      res_s5  <= res_s4;
    end
    if (adv[6]) begin
      rsec_s6 <= rsec_s5;
      res_s6  <= res_s5;
    end
  end

  // millisecond split: long division by 1000, one chunk per step
  logic [2*CHUNK_W-1:0] lo_s1, lo_s2;
  logic [CHUNK_W-1:0]   lo_s3, lo_s4;
  logic [CHUNK_W-1:0]   q0, q1, q2;
  logic [REM_W-1:0]     r0, r1, r2;
  logic [CHUNK_W-1:0]   q0_s3, q0_s4, q0_s5, q0_s6, q1_s5, q1_s6;

  always_ff @(posedge clk) begin
    if (adv[1]) lo_s1 <= smag[2*CHUNK_W-1:0];
    if (adv[2]) lo_s2 <= lo_s1;
    if (adv[3]) begin
      lo_s3 <= lo_s2[CHUNK_W-1:0];
      q0_s3 <= q0;
    end
    if (adv[4]) begin
      lo_s4 <= lo_s3;
      q0_s4 <= q0_s3;
    end
    if (adv[5]) begin
      q0_s5 <= q0_s4;
      q1_s5 <= q1;
    end
    if (adv[6]) begin
      q0_s6 <= q0_s5;
      q1_s6 <= q1_s5;
    end
  end

  ttva_div_step u_div0 (
    .clk    (clk),
    .en_mul (adv[1]),
    .en_rem (adv[2]),
    .x      ({{REM_W{1'b0}}, smag[MAG_W-1:2*CHUNK_W]}),
    .q      (q0),
    .rem    (r0)
  );

  ttva_div_step u_div1 (
    .clk    (clk),
    .en_mul (adv[3]),
    .en_rem (adv[4]),
    .x      ({r0, lo_s2[2*CHUNK_W-1:CHUNK_W]}),
    .q      (q1),
    .rem    (r1)
  );

  ttva_div_step u_div2 (
    .clk    (clk),
    .en_mul (adv[5]),
    .en_rem (adv[6]),
    .x      ({r1, lo_s4}),
    .q      (q2),
    .rem    (r2)
  );

  // output stage
  logic [MAG_W-1:0]         qq;
  logic signed [MAG_W:0]    rsd;
  logic [DIV_X_W-1:0]       msns;
  logic signed [NSEC_W-1:0] nsv;
  logic                     err_d;

  always_comb begin
    qq    = {q0_s6, q1_s6, q2};
    rsd   = sneg[ST_N-2] ? -$signed({1'b0, qq}) : $signed({1'b0, qq});
    msns  = DIV_X_W'(r2) * DIV_X_W'(NS_PER_MS);
    nsv   = sneg[ST_N-2] ? -$signed(NSEC_W'(msns)) : $signed(NSEC_W'(msns));
    err_d = ((op_t'(opq[ST_N-2]) == OP_FROM_MS_ABS) && sneg[ST_N-2]) ||
            !((&rsd[MAG_W:SW-1]) || !(|rsd[MAG_W:SW-1]));
  end

  always_ff @(posedge clk) begin
    if (adv[ST_N-1]) begin
      case (op_t'(opq[ST_N-2]))
        OP_FROM_MS_REL, OP_FROM_MS_ABS: begin
          r_sec      <= rsd[SW-1:0];
          r_nsec     <= {nsv[NSEC_W-1:1],
                         op_t'(opq[ST_N-2]) == OP_FROM_MS_REL};
          order      <= ORD_EQ;
          serial_out <= '0;
          error      <= err_d;
        end
        default: begin
          r_sec      <= rsec_s6;
          r_nsec     <= res_s6.r_nsec;
          order      <= res_s6.order;
          serial_out <= res_s6.serial_out;
          error      <= res_s6.error;
        end
      endcase
    end
  end

  a_order_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (order == ORD_LT || order == ORD_EQ || order == ORD_GT))
    else $error("order code out of range");

  a_nsec_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ($signed(r_nsec) < NS_PER_SEC && $signed(r_nsec) > -NS_PER_SEC))
    else $error("nanoseconds not normalised");

  a_no_time: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (opq[ST_N-1] == OP_CMP || opq[ST_N-1] == OP_TO_MS)
      |-> (r_sec == '0 && r_nsec == '0))
    else $error("time fields set on a non-time result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    vld[TIME_ST-1] && !adv[TIME_ST] |=> vld[TIME_ST-1])
    else $error("stalled word dropped");

endmodule
`default_nettype wire

// File: tb/sv/tagged_time_value_alu_core_tb.sv
// ----------------------------------------------------------------------------
// Tagged time value ALU testbench
// Walks a table of directed time-value operations and then several hundred
// random ones through the core. Both handshakes idle and stall at random.
// Every response word is checked field by field against a behavioural
// predictor, or against a typed-in value for the plain directed cases.
// ----------------------------------------------------------------------------
module tagged_time_value_alu_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttva_pkg::*;

  localparam int SEC_BITS = SEC_BITS_DEF;

  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  localparam int GAP_MAX         = 12;
  localparam int LONG_HOLD       = 60;
  localparam int HOLD_AT_RESULT  = 130;
  localparam int DRAIN_AT_WORD   = 330;
  localparam int RANDOM_WORDS    = 450;
  localparam int SETTLE_CYCLES   = 20;
  localparam int WATCHDOG_CYCLES = 2000;

  localparam logic signed [SEC_BITS-1:0] SEC_MAX  = {1'b0, {(SEC_BITS-1){1'b1}}};
  localparam logic signed [SEC_BITS-1:0] SEC_MIN  = {1'b1, {(SEC_BITS-1){1'b0}}};
  localparam logic signed [NSEC_W-1:0]   NSEC_MAX = {1'b0, {(NSEC_W-1){1'b1}}};
  localparam logic signed [NSEC_W-1:0]   NSEC_MIN = {1'b1, {(NSEC_W-1){1'b0}}};
  localparam logic signed [SER_W-1:0]    SER_MAX  = {1'b0, {(SER_W-1){1'b1}}};
  localparam logic signed [SER_W-1:0]    SER_MIN  = {1'b1, {(SER_W-1){1'b0}}};

  typedef struct packed {
    logic [OP_W-1:0]            op;
    logic signed [SEC_BITS-1:0] a_sec;
    logic signed [NSEC_W-1:0]   a_nsec;
    logic signed [SEC_BITS-1:0] b_sec;
    logic signed [NSEC_W-1:0]   b_nsec;
    logic signed [SER_W-1:0]    serial_in;
  } time_op_t;

  typedef struct packed {
    logic signed [SEC_BITS-1:0] r_sec;
    logic signed [NSEC_W-1:0]   r_nsec;
    logic signed [ORD_W-1:0]    order;
    logic signed [SER_W-1:0]    serial_out;
    logic                       error;
  } time_result_t;

  typedef struct packed {
    time_op_t     op_word;
    logic         typed;
    time_result_t result;
  } directed_row_t;

  localparam time_result_t NO_RESULT = '0;

  logic                       clk;
  logic                       rst       = 1'b1;
  logic                       req_valid = 1'b0;
  logic                       req_ready;
  logic [OP_W-1:0]            op        = '0;
  logic signed [SEC_BITS-1:0] a_sec     = '0;
  logic signed [NSEC_W-1:0]   a_nsec    = '0;
  logic signed [SEC_BITS-1:0] b_sec     = '0;
  logic signed [NSEC_W-1:0]   b_nsec    = '0;
  logic signed [SER_W-1:0]    serial_in = '0;
  logic                       rsp_valid;
  logic                       rsp_ready = 1'b0;
  logic signed [SEC_BITS-1:0] r_sec;
  logic signed [NSEC_W-1:0]   r_nsec;
  logic signed [ORD_W-1:0]    order;
  logic signed [SER_W-1:0]    serial_out;
  logic                       error;

  time_result_t pending_results [$];
  int           mismatches   = 0;
  int           results_seen = 0;

  directed_row_t directed_rows [25] = '{
    '{'{OP_RSVD6, 48'sd0, 31'sd0, 48'sd0, 31'sd0, 58'sd0}, 1'b1,
      '{48'sd0, 31'sd0, ORD_EQ, 58'sd0, 1'b1}},
    '{'{OP_RSVD7, SEC_MAX, NSEC_MAX, SEC_MIN, NSEC_MIN, SER_MAX}, 1'b1,
      '{48'sd0, 31'sd0, ORD_EQ, 58'sd0, 1'b1}},
    '{'{OP_ADD, 48'sd1, 31'sd500000001, 48'sd2, 31'sd600000001, 58'sd0}, 1'b0, NO_RESULT},
    '{'{OP_ADD, 48'sd1, 31'sd0, 48'sd2, 31'sd0, 58'sd0}, 1'b1,
      '{48'sd3, 31'sd0, ORD_EQ, 58'sd0, 1'b1}},
    '{'{OP_ADD, -48'sd3, 31'sd200000000, 48'sd1, -31'sd700000001, 58'sd0}, 1'b0, NO_RESULT},
    '{'{OP_ADD, 48'sd4, 31'sd1, 48'sd5, 31'sd999999998, 58'sd0}, 1'b0, NO_RESULT},
    '{'{OP_ADD, SEC_MAX, 31'sd1, SEC_MAX, 31'sd1, 58'sd0}, 1'b0, NO_RESULT},
    '{'{OP_ADD, 48'sd0, NSEC_MIN, 48'sd0, NSEC_MAX, 58'sd0}, 1'b0, NO_RESULT},
    '{'{OP_SUB, 48'sd5, 31'sd0, 48'sd7, 31'sd0, 58'sd0}, 1'b0, NO_RESULT},
    '{'{OP_SUB, 48'sd5, 31'sd1, 48'sd2, 31'sd0, 58'sd0}, 1'b1,
      '{48'sd3, 31'sd1, ORD_EQ, 58'sd0, 1'b1}},
    '{'{OP_SUB, 48'sd1, 31'sd0, 48'sd3, 31'sd1, 58'sd0}, 1'b0, NO_RESULT},
    '{'{OP_SUB, -48'sd2, -31'sd300000001, 48'sd1, 31'sd900000001, 58'sd0}, 1'b0, NO_RESULT},
    '{'{OP_SUB, SEC_MIN, NSEC_MIN, SEC_MAX, NSEC_MAX, 58'sd0}, 1'b0, NO_RESULT},
    '{'{OP_CMP, 48'sd3, 31'sd10, 48'sd3, 31'sd10, 58'sd0}, 1'b1,
      '{48'sd0, 31'sd0, ORD_EQ, 58'sd0, 1'b0}},
    '{'{OP_CMP, 48'sd3, 31'sd10, 48'sd3, 31'sd11, 58'sd0}, 1'b1,
      '{48'sd0, 31'sd0, ORD_LT, 58'sd0, 1'b1}},
    '{'{OP_CMP, SEC_MAX, 31'sd0, SEC_MIN, 31'sd0, 58'sd0}, 1'b1,
      '{48'sd0, 31'sd0, ORD_GT, 58'sd0, 1'b0}},
    '{'{OP_CMP, -48'sd7, -31'sd1, -48'sd7, -31'sd3, 58'sd0}, 1'b0, NO_RESULT},
    '{'{OP_TO_MS, SEC_MAX, NSEC_MAX, 48'sd0, 31'sd0, 58'sd0}, 1'b0, NO_RESULT},
    '{'{OP_TO_MS, SEC_MIN, NSEC_MIN, 48'sd0, 31'sd0, 58'sd0}, 1'b0, NO_RESULT},
    '{'{OP_TO_MS, -48'sd1, -31'sd999999, 48'sd0, 31'sd0, 58'sd0}, 1'b0, NO_RESULT},
    '{'{OP_FROM_MS_REL, 48'sd0, 31'sd0, 48'sd0, 31'sd0, 58'sd0}, 1'b1,
      '{48'sd0, 31'sd1, ORD_EQ, 58'sd0, 1'b0}},
    '{'{OP_FROM_MS_ABS, 48'sd0, 31'sd0, 48'sd0, 31'sd0, -58'sd1}, 1'b1,
      '{48'sd0, -31'sd1000000, ORD_EQ, 58'sd0, 1'b1}},
    '{'{OP_FROM_MS_ABS, 48'sd0, 31'sd0, 48'sd0, 31'sd0, SER_MAX}, 1'b0, NO_RESULT},
    '{'{OP_FROM_MS_REL, 48'sd0, 31'sd0, 48'sd0, 31'sd0, SER_MIN}, 1'b0, NO_RESULT},
    '{'{OP_FROM_MS_ABS, 48'sd0, 31'sd0, 48'sd0, 31'sd0, 58'sd1234567}, 1'b0, NO_RESULT}
  };

  tagged_time_value_alu_core #(.SEC_BITS(SEC_BITS)) uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit in_signed_range(input longint v, input int w);
    longint hi;
    hi = (longint'(1) << (w - 1)) - 64'sd1;
    return v <= hi && v >= -hi - 64'sd1;
  endfunction

  function automatic time_result_t predict_time_op(input time_op_t w);
    longint       as_v, an_v, bs_v, bn_v, ser_v, rs, rn, so, carry;
    logic         a_rel, b_rel, err, timed;
    logic [ORD_W-1:0] ord;
    time_result_t r;
    as_v  = longint'(w.a_sec);
    an_v  = longint'(w.a_nsec);
    bs_v  = longint'(w.b_sec);
    bn_v  = longint'(w.b_nsec);
    ser_v = longint'(w.serial_in);
    a_rel = an_v[0];
    b_rel = bn_v[0];
    rs    = 0;
    rn    = 0;
    so    = 0;
    ord   = ORD_EQ;
    err   = 1'b0;
    timed = 1'b0;
    case (w.op)
      OP_ADD: begin
        err = !a_rel && !b_rel;
        rn  = an_v + (bn_v - longint'(b_rel));
        if (!b_rel) rn[0] = 1'b0;
        rs    = as_v + bs_v;
        timed = 1'b1;
      end
      OP_SUB: begin
        err = a_rel && !b_rel;
        rn  = an_v - (bn_v - longint'(b_rel));
        if (!b_rel) rn[0] = 1'b1;
        rs    = as_v - bs_v;
        timed = 1'b1;
      end
      OP_CMP: begin
        err = a_rel != b_rel;
        if (as_v != bs_v) ord = (as_v < bs_v) ? ORD_LT : ORD_GT;
        else if (an_v != bn_v) ord = (an_v < bn_v) ? ORD_LT : ORD_GT;
      end
      OP_TO_MS: begin
        so  = as_v * MS_PER_SEC + an_v / NS_PER_MS;
        err = as_v >= (longint'(1) << 53) || as_v <= -(longint'(1) << 53) ||
              !in_signed_range(so, SER_W);
      end
      OP_FROM_MS_REL, OP_FROM_MS_ABS: begin
        rs = ser_v / MS_PER_SEC;
        rn = (ser_v % MS_PER_SEC) * NS_PER_MS;
        if (w.op == OP_FROM_MS_REL) rn = rn + 64'sd1;
        else err = ser_v < 0;
        err = err || !in_signed_range(rs, SEC_BITS);
      end
      default: begin
        err = 1'b1;
      end
    endcase
    if (timed) begin
      carry = rn / NS_PER_SEC;
      rn    = rn - carry * NS_PER_SEC;
      rs    = rs + carry;
      if (rs > 0 && rn < 0) begin
        rn = rn + NS_PER_SEC;
        rs = rs - 64'sd1;
      end else if (rs < 0 && rn > 0) begin
        rn = rn - NS_PER_SEC;
        rs = rs + 64'sd1;
      end
      if (!rn[0] && (rs < 0 || rn < 0)) err = 1'b1;
      if (!in_signed_range(rs, SEC_BITS)) err = 1'b1;
    end
    r.r_sec      = rs[SEC_BITS-1:0];
    r.r_nsec     = rn[NSEC_W-1:0];
    r.order      = ord;
    r.serial_out = so[SER_W-1:0];
    r.error      = err;
    return r;
  endfunction

  function automatic logic signed [SEC_BITS-1:0] near_seconds();
    return SEC_BITS'(longint'($urandom_range(0, 20000)) - 64'sd10000);
  endfunction

  function automatic logic signed [NSEC_W-1:0] near_nsec();
    return NSEC_W'(longint'($urandom_range(0, 1999999998)) - 64'sd999999999);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task automatic issue_time_op(input time_op_t w, input logic typed,
                               input time_result_t typed_result, input int gap,
                               input bit drain_first);
    time_result_t want;
    want = typed ? typed_result : predict_time_op(w);
    if (drain_first || gap > 0) begin
      req_valid <= 1'b0;
      if (drain_first) begin
        do @(posedge clk); while (pending_results.size() != 0);
      end
      repeat (gap) @(posedge clk);
    end
    {op, a_sec, a_nsec, b_sec, b_nsec, serial_in} <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pending_results.push_back(want);
  endtask

  initial begin : stimulus
    int          gap;
    time_op_t    w;
    logic [63:0] raw_a, raw_b, raw_s;
    int          pick;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      issue_time_op(directed_rows[i].op_word, directed_rows[i].typed,
                    directed_rows[i].result, $urandom_range(0, GAP_MAX), 1'b0);
    end
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      raw_a = {$urandom, $urandom};
      raw_b = {$urandom, $urandom};
      raw_s = {$urandom, $urandom};
      pick  = $urandom_range(0, 99);
      if (pick < 2) w.op = OP_RSVD6;
      else if (pick < 4) w.op = OP_RSVD7;
      else w.op = OP_W'($urandom_range(0, 5));
      w.a_sec     = ($urandom_range(0, 3) == 0) ? raw_a[SEC_BITS-1:0] : near_seconds();
      w.b_sec     = ($urandom_range(0, 3) == 0) ? raw_b[SEC_BITS-1:0] : near_seconds();
      w.a_nsec    = ($urandom_range(0, 3) == 0) ? NSEC_W'($urandom) : near_nsec();
      w.b_nsec    = ($urandom_range(0, 3) == 0) ? NSEC_W'($urandom) : near_nsec();
      w.serial_in = ($urandom_range(0, 3) == 0) ? raw_s[SER_W-1:0] :
                    SER_W'(longint'($urandom_range(0, 2000000)) - 64'sd1000000);
      // tie seconds, and sometimes nanoseconds up to the tag, for compare
      if (w.op == OP_CMP && $urandom_range(0, 1) == 1) begin
        w.b_sec = w.a_sec;
        if ($urandom_range(0, 1) == 1) w.b_nsec = w.a_nsec ^ NSEC_W'($urandom_range(0, 1));
      end
      if ((i >= 90 && i < 220) || (i / 40) % 3 == 1) gap = 0;
      else gap = $urandom_range(0, GAP_MAX);
      issue_time_op(w, 1'b0, NO_RESULT, gap, i == DRAIN_AT_WORD);
    end
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : response_side
    int           gap;
    time_result_t got, want;
    while (rst) @(posedge clk);
    forever begin
      if (results_seen == HOLD_AT_RESULT) gap = LONG_HOLD;
      else if ((results_seen / 50) % 3 == 2) gap = 0;
      else gap = $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      got = {r_sec, r_nsec, order, serial_out, error};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing pending", results_seen));
      end else begin
        want = pending_results.pop_front();
        if (got.r_sec !== want.r_sec)
          report_mismatch($sformatf("word %0d r_sec %0d, expected %0d",
                                    results_seen, got.r_sec, want.r_sec));
        if (got.r_nsec !== want.r_nsec)
          report_mismatch($sformatf("word %0d r_nsec %0d, expected %0d",
                                    results_seen, got.r_nsec, want.r_nsec));
        if (got.order !== want.order)
          report_mismatch($sformatf("word %0d order %0d, expected %0d",
                                    results_seen, got.order, want.order));
        if (got.serial_out !== want.serial_out)
          report_mismatch($sformatf("word %0d serial_out %0d, expected %0d",
                                    results_seen, got.serial_out, want.serial_out));
        if (got.error !== want.error)
          report_mismatch($sformatf("word %0d error %0b, expected %0b",
                                    results_seen, got.error, want.error));
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
src/ttva_pkg.sv
src/ttva_div_step.sv
src/ttva_time.sv
src/tagged_time_value_alu_core.sv
tb/sv/tagged_time_value_alu_core_tb.sv
